[hdl/wov_pkg.sv]
// Shared types, constants and decode functions of the wavetable oscillator voice.
package wov_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int SLOT_W      = 4;
    localparam int ENTRY_W     = 12;
    localparam int CLS_W       = 2;
    localparam int NOTE_W      = 7;
    localparam int WAVE_ADDR_W = SLOT_W + ENTRY_W;
    localparam int RATE_ADDR_W = CLS_W + NOTE_W;
    localparam int WAVE_WORDS  = 1 << WAVE_ADDR_W;
    localparam int RATE_WORDS  = 384;

    // Result buffer and command queue depths.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Command codes of the input word.
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd2;
    localparam logic [2:0] CMD_WAVE_WR  = 3'd3;
    localparam logic [2:0] CMD_RATE_WR  = 3'd4;

    // Waveshape codes.
    localparam logic [1:0] SHAPE_SAW    = 2'd1;
    localparam logic [1:0] SHAPE_SQUARE = 2'd2;

    // Table size classes.
    localparam logic [CLS_W-1:0] CLS_4096 = 2'd0;
    localparam logic [CLS_W-1:0] CLS_2048 = 2'd1;
    localparam logic [CLS_W-1:0] CLS_1024 = 2'd2;

    localparam logic [PHASE_W-1:0] MASK_4096 = 32'h0fff_ffff;
    localparam logic [PHASE_W-1:0] MASK_2048 = 32'h07ff_ffff;
    localparam logic [PHASE_W-1:0] MASK_1024 = 32'h03ff_ffff;
    localparam logic [PHASE_W-1:0] PHASE_ONE = 32'h0001_0000;
    localparam logic [15:0]        FRAC_MAX  = 16'hffff;

    // note / 12 as (note * 171) >> 11, exact for all 7-bit notes.
    localparam logic [7:0] OCT_RECIP = 8'd171;
    localparam logic [3:0] OCT2_MIN  = 4'd3;
    localparam logic [3:0] OCT2_MAX  = 4'd10;
    localparam logic [3:0] OCT_BIAS  = 4'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_NOTE_ON,
        OP_NOTE_REJ,
        OP_NOTE_OFF,
        OP_WAVE_WR,
        OP_RATE_WR
    } t_op_kind;

    typedef struct packed {
        t_op_kind                  kind;
        logic [SLOT_W-1:0]         slot;
        logic [CLS_W-1:0]          cls;
        logic [RATE_ADDR_W-1:0]    rate_addr;
        logic [WAVE_ADDR_W-1:0]    wave_addr;
        logic signed [SAMPLE_W-1:0] wave_value;
        logic [PHASE_W-1:0]        rate_value;
    } t_op;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       playing;
        logic                       rejected;
    } t_result;

    function automatic logic [3:0] oct_plus2(input logic [NOTE_W-1:0] note);
        logic [14:0] prod;
        prod = {8'd0, note} * {7'd0, OCT_RECIP};
        return prod[14:11];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] shape,
                                                  input logic [3:0] octave);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        case (shape)
            SHAPE_SAW:    slot = (octave <= 4'd7) ? octave : '0;
            SHAPE_SQUARE: slot = (octave <= 4'd6) ? (octave + 4'd7) : '0;
            default:      slot = '0;
        endcase
        return slot;
    endfunction

    function automatic logic [CLS_W-1:0] cls_of(input logic [1:0] shape,
                                                input logic [3:0] octave);
        logic [CLS_W-1:0] cls;
        cls = CLS_4096;
        case (shape)
            SHAPE_SAW, SHAPE_SQUARE: begin
                if (octave <= 4'd2) begin
                    cls = CLS_4096;
                end else if (octave <= 4'd4) begin
                    cls = CLS_2048;
                end else begin
                    cls = CLS_1024;
                end
            end
            default: cls = CLS_4096;
        endcase
        return cls;
    endfunction

    function automatic logic [PHASE_W-1:0] mask_of(input logic [CLS_W-1:0] cls);
        logic [PHASE_W-1:0] mask;
        case (cls)
            CLS_4096: mask = MASK_4096;
            CLS_2048: mask = MASK_2048;
            default:  mask = MASK_1024;
        endcase
        return mask;
    endfunction

endpackage

[hdl/wov_if.sv]
// Handshake channels of the voice: command words in, result words out.
interface wov_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          command;
    logic [6:0]          note;
    logic [15:0]         wave_address;
    logic signed [15:0]  wave_value;
    logic [8:0]          rate_address;
    logic [31:0]         rate_value;

    modport source (output valid, command, note, wave_address, wave_value,
                    rate_address, rate_value, input ready);
    modport sink (input valid, command, note, wave_address, wave_value,
                  rate_address, rate_value, output ready);
endinterface

interface wov_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;
    logic                playing;
    logic                note_rejected;

    modport source (output valid, sample, playing, note_rejected, input ready);
    modport sink (input valid, sample, playing, note_rejected, output ready);
endinterface

[hdl/wov_front.sv]
// Front end: accepts command words, holds the waveshape register and decodes each word.
module wov_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata,
    wov_in_if.sink           i_in,
    output logic             o_op_valid,
    input  logic             i_op_ready,
    output wov_pkg::t_op     o_op
);

    logic [1:0]    r_waveshape;
    logic          r_valid;
    wov_pkg::t_op  r_op;
    wov_pkg::t_op  n_op;
    logic          accept;
    logic [3:0]    oct2;
    logic [3:0]    octave;
    logic          in_range;
    logic [wov_pkg::CLS_W-1:0] note_cls;

    assign i_in.ready = !r_valid || i_op_ready;
    assign accept     = i_in.valid && i_in.ready;

    assign oct2     = wov_pkg::oct_plus2(i_in.note);
    assign octave   = oct2 - wov_pkg::OCT_BIAS;
    assign in_range = (oct2 >= wov_pkg::OCT2_MIN) && (oct2 <= wov_pkg::OCT2_MAX);
    assign note_cls = wov_pkg::cls_of(r_waveshape, octave);

    always_comb begin
        n_op            = '0;
        n_op.kind       = wov_pkg::OP_NOP;
        n_op.wave_addr  = i_in.wave_address;
        n_op.wave_value = i_in.wave_value;
        n_op.rate_value = i_in.rate_value;
        n_op.rate_addr  = i_in.rate_address;
        unique case (i_in.command)
            wov_pkg::CMD_TICK: begin
                n_op.kind = wov_pkg::OP_TICK;
            end
            wov_pkg::CMD_NOTE_ON: begin
                if (in_range) begin
                    n_op.kind      = wov_pkg::OP_NOTE_ON;
                    n_op.slot      = wov_pkg::slot_of(r_waveshape, octave);
                    n_op.cls       = note_cls;
                    n_op.rate_addr = {note_cls, i_in.note};
                end else begin
                    n_op.kind = wov_pkg::OP_NOTE_REJ;
                end
            end
            wov_pkg::CMD_NOTE_OFF: begin
                n_op.kind = wov_pkg::OP_NOTE_OFF;
            end
            wov_pkg::CMD_WAVE_WR: begin
                n_op.kind = wov_pkg::OP_WAVE_WR;
            end
            wov_pkg::CMD_RATE_WR: begin
                // Writes past the end of the rate store are dropped.
                if (i_in.rate_address < wov_pkg::RATE_ADDR_W'(wov_pkg::RATE_WORDS)) begin
                    n_op.kind = wov_pkg::OP_RATE_WR;
                end
            end
            default: begin
                n_op.kind = wov_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_waveshape <= '0;
        end else begin
            if (i_cfg_we) begin
                r_waveshape <= i_cfg_wdata;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_op_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

[hdl/wov_queue.sv]
// Two-entry queue of decoded commands between the front and back ends.
module wov_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  wov_pkg::t_op     i_push_op,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output wov_pkg::t_op     o_pop_op
);

    wov_pkg::t_op                 r_q [wov_pkg::Q_DEPTH];
    logic [wov_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [wov_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [wov_pkg::Q_CNT_W-1:0]  r_cnt;
    logic                         push;
    logic                         pop;

    assign o_push_ready = r_cnt != wov_pkg::Q_CNT_W'(wov_pkg::Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_op     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + wov_pkg::Q_CNT_W'(push) - wov_pkg::Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

[hdl/wov_back.sv]
// Back end: voice state, wave and rate stores, interpolation pipeline and result buffer.
module wov_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    output logic             o_op_ready,
    input  wov_pkg::t_op     i_op,
    wov_out_if.source        o_out
);

    typedef enum logic [2:0] {
        ST_DISPATCH  = 3'b001,
        ST_TICK_B    = 3'b010,
        ST_NOTE_WAIT = 3'b100
    } t_state;

    t_state                               r_state;
    logic [wov_pkg::PHASE_W-1:0]          r_phase;
    logic [wov_pkg::PHASE_W-1:0]          r_inc;
    logic [wov_pkg::CLS_W-1:0]            r_cls;
    logic [wov_pkg::SLOT_W-1:0]           r_slot;
    logic                                 r_sounding;
    logic [wov_pkg::OUT_CNT_W-1:0]        r_used;

    logic [wov_pkg::WAVE_ADDR_W-1:0]      r_addr_b;
    logic [15:0]                          r_frac;

    logic signed [wov_pkg::SAMPLE_W-1:0]  r_wave_mem [wov_pkg::WAVE_WORDS];
    logic signed [wov_pkg::SAMPLE_W-1:0]  r_wave_rd;
    logic [wov_pkg::PHASE_W-1:0]          r_rate_mem [wov_pkg::RATE_WORDS];
    logic [wov_pkg::PHASE_W-1:0]          r_rate_rd;

    // Multiply stage.
    logic                                 r_p1_valid;
    logic                                 r_p1_is_tick;
    logic                                 r_p1_playing;
    logic                                 r_p1_rejected;
    logic signed [wov_pkg::SAMPLE_W-1:0]  r_p1_a;
    logic [15:0]                          r_p1_frac;
    // Sum and saturate stage.
    logic                                 r_p2_valid;
    logic                                 r_p2_is_tick;
    logic                                 r_p2_playing;
    logic                                 r_p2_rejected;
    logic signed [32:0]                   r_p2_pa;
    logic signed [32:0]                   r_p2_pb;

    wov_pkg::t_result                     r_fifo [wov_pkg::OUT_DEPTH];
    logic [wov_pkg::OUT_PTR_W-1:0]        r_wr_ptr;
    logic [wov_pkg::OUT_PTR_W-1:0]        r_rd_ptr;
    logic [wov_pkg::OUT_CNT_W-1:0]        r_cnt;

    logic                                 room;
    logic                                 pop;
    logic                                 tick_live;
    logic                                 p1_load;
    logic                                 p1_playing;
    logic                                 out_pop;
    logic [wov_pkg::PHASE_W-1:0]          mask;
    logic [wov_pkg::PHASE_W-1:0]          phase_sum;
    logic [wov_pkg::PHASE_W-1:0]          phase_new;
    logic [wov_pkg::PHASE_W-1:0]          phase_next;
    logic [wov_pkg::WAVE_ADDR_W-1:0]      wave_addr;
    logic                                 wave_we;
    logic [wov_pkg::RATE_ADDR_W-1:0]      rate_addr;
    logic                                 rate_we;
    logic signed [16:0]                   w_a;
    logic signed [16:0]                   w_b;
    logic signed [32:0]                   prod_a;
    logic signed [32:0]                   prod_b;
    logic signed [17:0]                   sum;
    logic signed [wov_pkg::SAMPLE_W-1:0]  sat;
    wov_pkg::t_result                     result;

    // A slot in the result buffer is reserved when a command is dispatched, so
    // the pipeline behind dispatch never has to stall.
    assign room       = r_used < wov_pkg::OUT_CNT_W'(wov_pkg::OUT_DEPTH);
    assign o_op_ready = (r_state == ST_DISPATCH) && room;
    assign pop        = i_op_valid && o_op_ready;
    assign tick_live  = (i_op.kind == wov_pkg::OP_TICK) && r_sounding;

    // Phase step for the tick being dispatched.
    assign mask       = wov_pkg::mask_of(r_cls);
    assign phase_sum  = r_phase + r_inc;
    assign phase_new  = phase_sum & mask;
    assign phase_next = (phase_sum + wov_pkg::PHASE_ONE) & mask;

    always_comb begin
        wave_addr = {r_slot, phase_new[wov_pkg::ENTRY_W+15:16]};
        wave_we   = 1'b0;
        if (r_state == ST_TICK_B) begin
            wave_addr = r_addr_b;
        end else if (pop && (i_op.kind == wov_pkg::OP_WAVE_WR)) begin
            wave_addr = i_op.wave_addr;
            wave_we   = 1'b1;
        end
    end

    assign rate_addr = i_op.rate_addr;
    assign rate_we   = pop && (i_op.kind == wov_pkg::OP_RATE_WR);

    always_ff @(posedge i_clk) begin
        if (wave_we) begin
            r_wave_mem[wave_addr] <= i_op.wave_value;
        end
        r_wave_rd <= r_wave_mem[wave_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rate_we) begin
            r_rate_mem[rate_addr] <= i_op.rate_value;
        end
        r_rate_rd <= r_rate_mem[rate_addr];
    end

    // Result word enters the pipeline at dispatch, except a sounding tick,
    // which enters while its second table entry is being read.
    assign p1_load = (pop && !tick_live) || (r_state == ST_TICK_B);

    always_comb begin
        p1_playing = r_sounding;
        if (r_state == ST_TICK_B) begin
            p1_playing = 1'b1;
        end else begin
            case (i_op.kind)
                wov_pkg::OP_NOTE_ON:  p1_playing = 1'b1;
                wov_pkg::OP_NOTE_OFF: p1_playing = 1'b0;
                default:              p1_playing = r_sounding;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_DISPATCH;
            r_phase    <= '0;
            r_inc      <= '0;
            r_cls      <= wov_pkg::CLS_4096;
            r_slot     <= '0;
            r_sounding <= 1'b0;
        end else begin
            unique case (r_state)
                ST_DISPATCH: begin
                    if (pop) begin
                        case (i_op.kind)
                            wov_pkg::OP_TICK: begin
                                if (r_sounding) begin
                                    r_phase <= phase_new;
                                    r_state <= ST_TICK_B;
                                end
                            end
                            wov_pkg::OP_NOTE_ON: begin
                                r_phase    <= '0;
                                r_slot     <= i_op.slot;
                                r_cls      <= i_op.cls;
                                r_sounding <= 1'b1;
                                r_state    <= ST_NOTE_WAIT;
                            end
                            wov_pkg::OP_NOTE_OFF: begin
                                r_sounding <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TICK_B: begin
                    r_state <= ST_DISPATCH;
                end
                ST_NOTE_WAIT: begin
                    r_inc   <= r_rate_rd;
                    r_state <= ST_DISPATCH;
                end
                default: begin
                    r_state <= ST_DISPATCH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && tick_live) begin
            r_addr_b <= {r_slot, phase_next[wov_pkg::ENTRY_W+15:16]};
            r_frac   <= phase_new[15:0];
        end
    end

    // Multiply stage: a times the inverted fraction, b times the fraction.
    assign w_a    = {1'b0, wov_pkg::FRAC_MAX - r_p1_frac};
    assign w_b    = {1'b0, r_p1_frac};
    assign prod_a = r_p1_a * w_a;
    assign prod_b = r_wave_rd * w_b;

    // Sum stage: arithmetic shifts floor each product, then saturate.
    assign sum = 18'(r_p2_pa >>> 16) + 18'(r_p2_pb >>> 16);

    always_comb begin
        if (sum > 18'sd32767) begin
            sat = 16'sh7fff;
        end else if (sum < -18'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = sum[15:0];
        end
    end

    always_comb begin
        result.sample   = r_p2_is_tick ? sat : '0;
        result.playing  = r_p2_playing;
        result.rejected = r_p2_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= p1_load;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_load) begin
            r_p1_is_tick  <= (r_state == ST_TICK_B);
            r_p1_playing  <= p1_playing;
            r_p1_rejected <= (r_state != ST_TICK_B) && (i_op.kind == wov_pkg::OP_NOTE_REJ);
            r_p1_a        <= r_wave_rd;
            r_p1_frac     <= r_frac;
        end
        r_p2_is_tick  <= r_p1_is_tick;
        r_p2_playing  <= r_p1_playing;
        r_p2_rejected <= r_p1_rejected;
        r_p2_pa       <= prod_a;
        r_p2_pb       <= prod_b;
    end

    // Result buffer.
    assign out_pop             = o_out.valid && o_out.ready;
    assign o_out.valid         = r_cnt != '0;
    assign o_out.sample        = r_fifo[r_rd_ptr].sample;
    assign o_out.playing       = r_fifo[r_rd_ptr].playing;
    assign o_out.note_rejected = r_fifo[r_rd_ptr].rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_used   <= '0;
        end else begin
            if (r_p2_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt  <= r_cnt + wov_pkg::OUT_CNT_W'(r_p2_valid)
                    - wov_pkg::OUT_CNT_W'(out_pop);
            r_used <= r_used + wov_pkg::OUT_CNT_W'(pop)
                    - wov_pkg::OUT_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_valid) begin
            r_fifo[r_wr_ptr] <= result;
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= wov_pkg::OUT_CNT_W'(wov_pkg::OUT_DEPTH))
        else $error("result reservations exceed the buffer depth");

    a_cnt_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_used)
        else $error("buffered results exceed reserved slots");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == wov_pkg::OUT_CNT_W'(wov_pkg::OUT_DEPTH)) |-> !r_p2_valid)
        else $error("push into a full result buffer");

    a_tick_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_B) |=> (r_p1_valid && r_p1_is_tick))
        else $error("tick did not enter the multiply stage");

    a_note_wait_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NOTE_WAIT) |-> r_sounding)
        else $error("increment load without a sounding voice");
`endif

endmodule

[hdl/wavetable_oscillator_voice_unit.sv]
// A word passes the front register and the queue; a sounding tick then waits for its second wave
// read, and every result goes through the multiply and sum stages into the result buffer.
// A sounding tick holds the back end for that second read on the single wave store port, a note-on
// for the registered read of the rate store that loads the phase increment; other words do not.
// Reset (synchronous, active low) clears phase, increment, slot, size class, sounding flag,
// waveshape and all handshake state; the wave and rate stores keep whatever they hold.
module wavetable_oscillator_voice_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    wov_in_if.sink      i_in,
    wov_out_if.source   o_out
);

    // The front end latches each incoming word and decodes it: the octave of a
    // note-on selects the table slot, the size class and the rate store address,
    // and out-of-range notes and rate writes are classified here so the back end
    // never has to look at the raw command.
    logic          front_valid;
    logic          front_ready;
    wov_pkg::t_op  front_op;

    // The queue lets the front end keep taking words while a sounding tick or a
    // note-on holds the back end.
    logic          back_valid;
    logic          back_ready;
    wov_pkg::t_op  back_op;

    wov_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_op_valid  (front_valid),
        .i_op_ready  (front_ready),
        .o_op        (front_op)
    );

    wov_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_op    (front_op),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_op     (back_op)
    );

    // The back end owns the voice state and both stores. A tick advances the
    // 16.16 phase, reads two adjacent wave entries on consecutive cycles, and
    // feeds them through a multiply stage and a sum-and-saturate stage into a
    // small result buffer. Every word reserves its buffer slot when it is
    // dispatched, so results leave in order and a stalled output side only
    // holds up dispatch, never the pipeline.
    wov_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (back_valid),
        .o_op_ready (back_ready),
        .i_op       (back_op),
        .o_out      (o_out)
    );

endmodule

[test/wavetable_oscillator_voice_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the oscillator voice: directed and random command words, checked in order.
module wavetable_oscillator_voice_unit_tb;
    import wov_pkg::*;

    // Run control. The watchdog limit is counted in cycles in which neither channel moves
    // a word; the longest legal quiet stretch is the receiver hold below.
    localparam int QUIET_LIMIT     = 2000;
    localparam int STALL_CYCLES    = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 50;
    localparam int WORDS_PER_SHAPE = 125;

    // Commands with no function in the voice, and the two waveshape codes the package
    // leaves unnamed.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [1:0] SHAPE_SINE      = 2'd0;
    localparam logic [1:0] SHAPE_SPARE     = 2'd3;

    // A note-on is played when note / 12 lies in 3..10 (octaves 1 to 8).
    localparam int         NOTES_PER_OCT       = 12;
    localparam int         OCT2_LOWEST         = 3;
    localparam int         OCT2_HIGHEST        = 10;
    localparam logic [6:0] FIRST_PLAYABLE_NOTE = 7'd36;
    localparam logic [6:0] LAST_REJECTED_NOTE  = 7'd35;
    localparam logic [6:0] TOP_NOTE            = 7'd127;

    typedef struct packed {
        logic [2:0]         command;
        logic [6:0]         note;
        logic [15:0]        wave_address;
        logic signed [15:0] wave_value;
        logic [8:0]         rate_address;
        logic [31:0]        rate_value;
    } voice_word_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    wov_in_if  in_ch ();
    wov_out_if out_ch ();

    wavetable_oscillator_voice_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Voice state as the testbench sees it. It is advanced once per accepted word, in
    // acceptance order, so the stimulus can always ask what the next tick will read.
    logic [1:0]         shape_reg;
    logic [31:0]        phase_acc;
    logic [31:0]        phase_step;
    logic [1:0]         size_cls;
    logic [3:0]         slot_sel;
    bit                 sounding;
    logic signed [15:0] wave_mem [int];
    logic [31:0]        rate_mem [RATE_WORDS];
    bit                 rate_known [RATE_WORDS];
    t_result            pending_results [$];
    t_result            head_result;

    int send_idle_pct;
    int recv_idle_pct;
    int rx_hold_cycles;
    int words_sent;
    int err_count;
    int quiet_cycles;

    always #2 i_clk = ~i_clk;

    // Phase wrap mask of each table size class.
    function automatic logic [31:0] wrap_mask(input logic [1:0] cls);
        logic [31:0] mask;
        case (cls)
            CLS_4096: mask = 32'h0fff_ffff;
            CLS_2048: mask = 32'h07ff_ffff;
            default:  mask = 32'h03ff_ffff;
        endcase
        return mask;
    endfunction

    // Table slot and size class that a playable note gets under the current waveshape.
    // The unused shape code plays as sine; the highest saw and square octaves fall back
    // to the sine slot but keep their own size class.
    function automatic void locate_table(input logic [6:0] note, output logic [3:0] slot,
                                         output logic [1:0] cls);
        int         octave;
        logic [1:0] shape;
        octave = int'(note) / NOTES_PER_OCT - 2;
        shape  = (shape_reg == SHAPE_SPARE) ? SHAPE_SINE : shape_reg;
        slot   = '0;
        cls    = CLS_4096;
        if (shape == SHAPE_SAW && octave <= 7) begin
            slot = octave[3:0];
        end
        if (shape == SHAPE_SQUARE && octave <= 6) begin
            slot = octave[3:0] + 4'd7;
        end
        if (shape != SHAPE_SINE) begin
            if (octave >= 5) begin
                cls = CLS_1024;
            end else if (octave >= 3) begin
                cls = CLS_2048;
            end
        end
    endfunction

    // Phase after the next tick and the two wave store addresses that tick reads.
    // The neighbor entry is the unmasked sum plus one entry, masked again, so it wraps to entry 0.
    function automatic void tick_reads(output logic [31:0] new_phase,
                                       output logic [15:0] addr_a, output logic [15:0] addr_b);
        logic [31:0] sum;
        logic [31:0] nxt;
        sum       = phase_acc + phase_step;
        nxt       = (sum + 32'h0001_0000) & wrap_mask(size_cls);
        new_phase = sum & wrap_mask(size_cls);
        addr_a    = {slot_sel, new_phase[27:16]};
        addr_b    = {slot_sel, nxt[27:16]};
    endfunction

    // Advances the voice state by one accepted word and queues the result it must give.
    task automatic predict_voice_result(input voice_word_t w);
        t_result     res;
        logic [31:0] np;
        logic [15:0] aa;
        logic [15:0] ab;
        logic [3:0]  slot;
        logic [1:0]  cls;
        int          oct2;
        int          frac;
        longint      mix;
        res.sample   = '0;
        res.rejected = 1'b0;
        case (w.command)
            CMD_TICK: begin
                if (sounding) begin
                    tick_reads(np, aa, ab);
                    phase_acc = np;
                    frac      = np[15:0];
                    // Each product is floored on its own before the sum.
                    mix = ((longint'(wave_mem[aa]) * (65535 - frac)) >>> 16)
                        + ((longint'(wave_mem[ab]) * frac) >>> 16);
                    if (mix > 32767) begin
                        mix = 32767;
                    end else if (mix < -32768) begin
                        mix = -32768;
                    end
                    res.sample = mix[15:0];
                end
            end
            CMD_NOTE_ON: begin
                oct2 = int'(w.note) / NOTES_PER_OCT;
                if (oct2 < OCT2_LOWEST || oct2 > OCT2_HIGHEST) begin
                    res.rejected = 1'b1;
                end else begin
                    locate_table(w.note, slot, cls);
                    phase_acc  = '0;
                    slot_sel   = slot;
                    size_cls   = cls;
                    phase_step = rate_mem[{cls, w.note}];
                    sounding   = 1'b1;
                end
            end
            CMD_NOTE_OFF: begin
                sounding = 1'b0;
            end
            CMD_WAVE_WR: begin
                wave_mem[w.wave_address] = w.wave_value;
            end
            CMD_RATE_WR: begin
                if (w.rate_address < RATE_WORDS) begin
                    rate_mem[w.rate_address]   = w.rate_value;
                    rate_known[w.rate_address] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.playing = sounding;
        pending_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Offers one word from a falling edge and holds it until the voice takes it. The
    // sender may first idle for a random number of cycles. Valid stays high after the
    // handshake, so anything that lets time pass without sending must park the input.
    task automatic send_word(input voice_word_t w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.command      = w.command;
        in_ch.note         = w.note;
        in_ch.wave_address = w.wave_address;
        in_ch.wave_value   = w.wave_value;
        in_ch.rate_address = w.rate_address;
        in_ch.rate_value   = w.rate_value;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        predict_voice_result(w);
        // Words the voice ignores outright do not count toward the stimulus length.
        if (w.command <= CMD_RATE_WR
                && !(w.command == CMD_RATE_WR && w.rate_address >= RATE_WORDS)) begin
            words_sent++;
        end
    endtask

    // Random content in every field, so the fields a command does not use still toggle.
    function automatic voice_word_t make_word(input logic [2:0] cmd);
        voice_word_t w;
        w.command      = cmd;
        w.note         = $urandom;
        w.wave_address = $urandom;
        w.wave_value   = $urandom;
        w.rate_address = $urandom;
        w.rate_value   = $urandom;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Small steps walk slowly through a table and reuse written entries; large ones jump.
    function automatic logic [31:0] rand_increment();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 32'h0004_0000);
            1:       v = $urandom_range(0, 32'h00ff_ffff);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_command(input logic [2:0] cmd);
        send_word(make_word(cmd));
    endtask

    task automatic write_wave_entry(input logic [15:0] addr, input logic signed [15:0] value);
        voice_word_t w;
        w              = make_word(CMD_WAVE_WR);
        w.wave_address = addr;
        w.wave_value   = value;
        send_word(w);
    endtask

    task automatic write_rate_entry(input logic [8:0] addr, input logic [31:0] value);
        voice_word_t w;
        w              = make_word(CMD_RATE_WR);
        w.rate_address = addr;
        w.rate_value   = value;
        send_word(w);
    endtask

    // A tick of a sounding voice reads two wave entries. Any that was never written is
    // written first, so no read ever touches an undefined entry.
    task automatic send_tick();
        logic [31:0] np;
        logic [15:0] aa;
        logic [15:0] ab;
        if (sounding) begin
            tick_reads(np, aa, ab);
            if (!wave_mem.exists(aa)) begin
                write_wave_entry(aa, rand_sample());
            end
            if (!wave_mem.exists(ab)) begin
                write_wave_entry(ab, rand_sample());
            end
        end
        send_command(CMD_TICK);
    endtask

    // A playable note loads its increment from the rate store, so the entry it will use
    // is written first if it never was. Rejected notes read nothing.
    task automatic send_note_on(input logic [6:0] note);
        voice_word_t w;
        logic [3:0]  slot;
        logic [1:0]  cls;
        if (note >= FIRST_PLAYABLE_NOTE) begin
            locate_table(note, slot, cls);
            if (!rate_known[{cls, note}]) begin
                write_rate_entry({cls, note}, rand_increment());
            end
        end
        w      = make_word(CMD_NOTE_ON);
        w.note = note;
        send_word(w);
    endtask

    // Lowers valid, waits for every queued result, then lets the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The waveshape register is only written with the voice idle.
    task automatic write_waveshape(input logic [1:0] shape);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = shape;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        shape_reg   = shape;
    endtask

    // One played note: note-on, a run of ticks with stray words now and then, and
    // often a note-off followed by a tick of the silent voice.
    task automatic play_phrase();
        int n_ticks;
        n_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        send_note_on($urandom_range(FIRST_PLAYABLE_NOTE, TOP_NOTE));
        repeat (n_ticks) begin
            if ($urandom_range(0, 15) == 0) begin
                send_noise();
            end
            send_tick();
        end
        if ($urandom_range(0, 1) == 1) begin
            send_command(CMD_NOTE_OFF);
            send_tick();
        end
    endtask

    // Stray words: rejected notes, spare commands, store writes anywhere (rate writes
    // past the end of the store included), note-offs and ticks.
    task automatic send_noise();
        logic [2:0] spare;
        case ($urandom_range(0, 5))
            0: send_note_on($urandom_range(0, LAST_REJECTED_NOTE));
            1: begin
                spare = $urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST);
                send_command(spare);
            end
            2: send_command(CMD_WAVE_WR);
            3: write_rate_entry($urandom_range(0, 511), rand_increment());
            4: send_command(CMD_NOTE_OFF);
            default: send_tick();
        endcase
    endtask

    task automatic run_shape_block(input logic [1:0] shape);
        int stop_at;
        write_waveshape(shape);
        stop_at = words_sent + WORDS_PER_SHAPE;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 70) begin
                play_phrase();
            end else begin
                send_noise();
            end
        end
    endtask

    // Extremes and corner cases, run with the waveshape at its reset value (sine).
    task automatic test_directed_extremes();
        // A silent voice answers every command with sample 0 and playing low.
        send_tick();
        send_command(CMD_NOTE_OFF);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            send_command(c[2:0]);
        end
        // Lowest and highest rejected notes leave the voice untouched.
        send_note_on(7'd0);
        send_note_on(LAST_REJECTED_NOTE);
        // Rate writes past the end of the store are dropped.
        write_rate_entry(RATE_WORDS, 32'hffff_ffff);
        write_rate_entry(9'h1ff, 32'h0000_0000);
        // Lowest playable note with a step just under one entry: the first tick
        // weights the neighbor almost fully, with both sample extremes in the table.
        write_rate_entry(FIRST_PLAYABLE_NOTE, 32'h0000_ffff);
        write_wave_entry(16'h0000, 16'sh8000);
        write_wave_entry(16'h0001, 16'sh7fff);
        write_wave_entry(16'h0002, 16'sh8000);
        send_note_on(FIRST_PLAYABLE_NOTE);
        send_tick();
        send_tick();
        // Last word of the wave store.
        write_wave_entry(16'hffff, 16'sh5a5a);
        // Top note with the largest step: the phase lands on the last entry and the
        // neighbor wraps around to entry 0.
        write_rate_entry({CLS_4096, TOP_NOTE}, 32'hffff_ffff);
        send_note_on(TOP_NOTE);
        send_tick();
        send_command(CMD_NOTE_OFF);
        send_tick();
    endtask

    // Random phrases under every waveshape, ending with sine at its reset value.
    task automatic test_random_phrases(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        run_shape_block(SHAPE_SAW);
        run_shape_block(SHAPE_SQUARE);
        run_shape_block(SHAPE_SPARE);
        run_shape_block(SHAPE_SINE);
    endtask

    // The receiver holds off long enough for the voice to fill up and stall its input
    // while the sender keeps offering ticks.
    task automatic test_output_stall();
        send_note_on($urandom_range(FIRST_PLAYABLE_NOTE, TOP_NOTE));
        rx_hold_cycles = STALL_CYCLES;
        repeat (40) send_tick();
    endtask

    // The sender pauses mid-note until every result is out; the phase must carry on.
    task automatic test_pause_until_drained();
        send_note_on($urandom_range(FIRST_PLAYABLE_NOTE, TOP_NOTE));
        repeat (6) send_tick();
        wait_idle();
        repeat (6) send_tick();
        send_command(CMD_NOTE_OFF);
        send_tick();
    endtask

    // Receiver: random stalls, or a counted hold when a test asks for one.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            rx_hold_cycles--;
        end else begin
            out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Each result word is checked against the oldest queued expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", out_ch.sample, 0);
            end else begin
                head_result = pending_results.pop_front();
                if (out_ch.sample !== head_result.sample) begin
                    report_mismatch("sample", out_ch.sample, head_result.sample);
                end
                if (out_ch.playing !== head_result.playing) begin
                    report_mismatch("playing", out_ch.playing, head_result.playing);
                end
                if (out_ch.note_rejected !== head_result.rejected) begin
                    report_mismatch("note_rejected", out_ch.note_rejected, head_result.rejected);
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = SHAPE_SINE;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_TICK;
        in_ch.note         = '0;
        in_ch.wave_address = '0;
        in_ch.wave_value   = '0;
        in_ch.rate_address = '0;
        in_ch.rate_value   = '0;
        out_ch.ready       = 1'b0;
        shape_reg          = SHAPE_SINE;
        phase_acc          = '0;
        phase_step         = '0;
        size_cls           = CLS_4096;
        slot_sel           = '0;
        sounding           = 1'b0;
        send_idle_pct      = 31;
        recv_idle_pct      = 60;
        rx_hold_cycles     = 0;
        words_sent         = 0;
        err_count          = 0;
        quiet_cycles       = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_random_phrases(31, 60);
        test_random_phrases(60, 31);
        test_random_phrases(0, 0);
        test_output_stall();
        test_pause_until_drained();
        wait_idle();

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/wov_pkg.sv
hdl/wov_if.sv
hdl/wov_front.sv
hdl/wov_queue.sv
hdl/wov_back.sv
hdl/wavetable_oscillator_voice_unit.sv
test/wavetable_oscillator_voice_unit_tb.sv
